// ===== sv/hffs_pkg.sv =====
// ----------------------------------------------------------------------------
// hffs_pkg: shared types and constants of the first-fit page store
// Transaction payloads, status codes, sequencer states and default sizes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hffs_pkg;

	localparam int MAX_PAGES_DEF      = 16;
	localparam int SLOTS_PER_PAGE_DEF = 16;
	localparam int SLOT_OVERHEAD_DEF  = 4;

	localparam logic [15:0] PAGE_HEADER_BYTES = 16'd16;
	localparam logic [15:0] PAGE_BYTES_RESET  = 16'd256;

	typedef enum logic [2:0] {
		ST_INSERTED   = 3'd0,
		ST_TOO_LARGE  = 3'd1,
		ST_STORE_FULL = 3'd2,
		ST_FOUND      = 3'd3,
		ST_NOT_FOUND  = 3'd4
	} status_t;

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_SEARCH = 1'b1
	} cmd_t;

	typedef struct packed {
		cmd_t               cmd;
		logic [15:0]        payload_len;
		logic signed [31:0] record_key;
	} req_item_t;

	typedef struct packed {
		status_t    status;
		logic [3:0] page_index;
		logic [3:0] slot_index;
		logic [4:0] pages_in_use;
	} rsp_item_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_INS_RD,
		S_INS_CHK,
		S_INS_NEW,
		S_SRC_PG,
		S_SRC_CNT,
		S_SRC_RD,
		S_SRC_CMP,
		S_FINISH
	} state_t;

endpackage

// ===== sv/heap_file_first_fit_store_top.sv =====
// ----------------------------------------------------------------------------
// heap_file_first_fit_store_top: first-fit page store
// Insert places a record in the lowest page with room, appending a page when
// none fits; search walks pages and slots in order for the first key match.
// Insert: reads and checks each allocated page in turn, appends a page if none
//   fits, then outputs; the page table read port sets the pace.
// Search: reads each page's slot count, then reads and compares each stored key;
//   the key memory port sets the pace.
// One transaction at a time; a finished result may wait while the next is taken.
// Reset clears control state and page count; no clearing pass, pages are
//   initialized when appended.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module heap_file_first_fit_store_top #(
	parameter int MAX_PAGES      = hffs_pkg::MAX_PAGES_DEF,
	parameter int SLOTS_PER_PAGE = hffs_pkg::SLOTS_PER_PAGE_DEF,
	parameter int SLOT_OVERHEAD  = hffs_pkg::SLOT_OVERHEAD_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  hffs_pkg::req_item_t req_data,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output hffs_pkg::rsp_item_t rsp_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [15:0]         cfg_data
);
	import hffs_pkg::*;

	localparam int PW    = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
	localparam int TW    = $clog2(MAX_PAGES + 1);
	localparam int SW    = (SLOTS_PER_PAGE > 1) ? $clog2(SLOTS_PER_PAGE) : 1;
	localparam int CW    = $clog2(SLOTS_PER_PAGE + 1);
	localparam int KDEP  = MAX_PAGES * SLOTS_PER_PAGE;
	localparam int KW    = (KDEP > 1) ? $clog2(KDEP) : 1;

	state_t          state_q, state_d;
	logic [PW-1:0]   p_q, p_d;
	logic [SW-1:0]   s_q, s_d;
	logic [CW-1:0]   cnt_q, cnt_d;
	logic [TW-1:0]   total_q, total_d;
	status_t         res_status_q, res_status_d;
	logic [PW-1:0]   res_page_q, res_page_d;
	logic [SW-1:0]   res_slot_q, res_slot_d;
	logic [15:0]     page_bytes_q;
	logic            rsp_valid_q;
	rsp_item_t       rsp_q;

	logic [15:0]     size_q;
	logic [31:0]     key_q;

	logic [15:0]     used_mem [MAX_PAGES];
	logic [CW-1:0]   cnt_mem [MAX_PAGES];
	logic [31:0]     key_mem [KDEP];
	logic [15:0]     used_rd_q;
	logic [CW-1:0]   cnt_rd_q;
	logic [31:0]     key_rd_q;

	logic            accept;
	logic            load_rsp;
	logic            pg_we;
	logic [PW-1:0]   pg_waddr;
	logic [15:0]     pg_wused;
	logic [CW-1:0]   pg_wcnt;
	logic            key_we;
	logic [PW-1:0]   ka_page;
	logic [SW-1:0]   ka_slot;
	logic [KW-1:0]   ka;

	// shared fit check
	logic [15:0]     chk_used;
	logic [CW-1:0]   chk_cnt;
	logic [17:0]     chk_sum;
	logic            chk_fit;
	logic            last_page;
	logic            last_slot;

	logic [PW+3:0]   pg_ext;
	logic [SW+3:0]   sl_ext;
	logic [TW+4:0]   tot_ext;

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	assign chk_used  = (state_q == S_INS_NEW) ? PAGE_HEADER_BYTES : used_rd_q;
	assign chk_cnt   = (state_q == S_INS_NEW) ? '0 : cnt_rd_q;
	assign chk_sum   = {2'b00, chk_used} + {2'b00, size_q} + 18'(SLOT_OVERHEAD);
	assign chk_fit   = (chk_used < page_bytes_q) && (chk_sum <= {2'b00, page_bytes_q})
		&& (chk_cnt < CW'(SLOTS_PER_PAGE));
	assign last_page = ((TW'(p_q) + TW'(1)) == total_q);
	assign last_slot = ((CW'(s_q) + CW'(1)) == cnt_q);

	assign ka = KW'(ka_page) * KW'(SLOTS_PER_PAGE) + KW'(ka_slot);

	assign pg_ext  = (PW + 4)'(res_page_q);
	assign sl_ext  = (SW + 4)'(res_slot_q);
	assign tot_ext = (TW + 5)'(total_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			p_q          <= '0;
			s_q          <= '0;
			cnt_q        <= '0;
			total_q      <= '0;
			res_status_q <= ST_NOT_FOUND;
			res_page_q   <= '0;
			res_slot_q   <= '0;
			page_bytes_q <= PAGE_BYTES_RESET;
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			p_q          <= p_d;
			s_q          <= s_d;
			cnt_q        <= cnt_d;
			total_q      <= total_d;
			res_status_q <= res_status_d;
			res_page_q   <= res_page_d;
			res_slot_q   <= res_slot_d;
			if (cfg_valid && cfg_ready) begin
				page_bytes_q <= cfg_data;
			end
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			size_q <= req_data.payload_len;
			key_q  <= req_data.record_key;
		end
		if (load_rsp) begin
			rsp_q.status       <= res_status_q;
			rsp_q.page_index   <= pg_ext[3:0];
			rsp_q.slot_index   <= sl_ext[3:0];
			rsp_q.pages_in_use <= tot_ext[4:0];
		end
	end

	// page table
	always_ff @(posedge clk) begin
		if (pg_we) begin
			used_mem[pg_waddr] <= pg_wused;
			cnt_mem[pg_waddr]  <= pg_wcnt;
		end
		used_rd_q <= used_mem[p_q];
		cnt_rd_q  <= cnt_mem[p_q];
	end

	// key store
	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[ka] <= key_q;
		end
		key_rd_q <= key_mem[ka];
	end

	always_comb begin
		state_d      = state_q;
		p_d          = p_q;
		s_d          = s_q;
		cnt_d        = cnt_q;
		total_d      = total_q;
		res_status_d = res_status_q;
		res_page_d   = res_page_q;
		res_slot_d   = res_slot_q;
		load_rsp     = 1'b0;
		pg_we        = 1'b0;
		pg_waddr     = p_q;
		pg_wused     = chk_sum[15:0];
		pg_wcnt      = chk_cnt + CW'(1);
		key_we       = 1'b0;
		ka_page      = p_q;
		ka_slot      = s_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					p_d        = '0;
					res_page_d = '0;
					res_slot_d = '0;
					if (req_data.cmd == CMD_INSERT) begin
						state_d = (total_q == '0) ? S_INS_NEW : S_INS_RD;
					end else if (total_q == '0) begin
						res_status_d = ST_NOT_FOUND;
						state_d      = S_FINISH;
					end else begin
						state_d = S_SRC_PG;
					end
				end
			end
			S_INS_RD: begin
				state_d = S_INS_CHK;
			end
			S_INS_CHK: begin
				ka_slot = cnt_rd_q[SW-1:0];
				if (chk_fit) begin
					pg_we        = 1'b1;
					key_we       = 1'b1;
					res_status_d = ST_INSERTED;
					res_page_d   = p_q;
					res_slot_d   = cnt_rd_q[SW-1:0];
					state_d      = S_FINISH;
				end else if (last_page) begin
					state_d = S_INS_NEW;
				end else begin
					p_d     = p_q + PW'(1);
					state_d = S_INS_RD;
				end
			end
			S_INS_NEW: begin
				ka_page  = total_q[PW-1:0];
				ka_slot  = '0;
				pg_waddr = total_q[PW-1:0];
				state_d  = S_FINISH;
				if (total_q == TW'(MAX_PAGES)) begin
					res_status_d = ST_STORE_FULL;
					res_page_d   = '0;
					res_slot_d   = '0;
				end else begin
					pg_we      = 1'b1;
					total_d    = total_q + TW'(1);
					res_page_d = total_q[PW-1:0];
					res_slot_d = '0;
					if (chk_fit) begin
						key_we       = 1'b1;
						res_status_d = ST_INSERTED;
					end else begin
						pg_wused     = PAGE_HEADER_BYTES;
						pg_wcnt      = '0;
						res_status_d = ST_TOO_LARGE;
					end
				end
			end
			S_SRC_PG: begin
				state_d = S_SRC_CNT;
			end
			S_SRC_CNT: begin
				cnt_d = cnt_rd_q;
				s_d   = '0;
				if (cnt_rd_q != '0) begin
					state_d = S_SRC_RD;
				end else if (last_page) begin
					res_status_d = ST_NOT_FOUND;
					state_d      = S_FINISH;
				end else begin
					p_d     = p_q + PW'(1);
					state_d = S_SRC_PG;
				end
			end
			S_SRC_RD: begin
				state_d = S_SRC_CMP;
			end
			S_SRC_CMP: begin
				if (key_rd_q == key_q) begin
					res_status_d = ST_FOUND;
					res_page_d   = p_q;
					res_slot_d   = s_q;
					state_d      = S_FINISH;
				end else if (!last_slot) begin
					s_d     = s_q + SW'(1);
					state_d = S_SRC_RD;
				end else if (last_page) begin
					res_status_d = ST_NOT_FOUND;
					state_d      = S_FINISH;
				end else begin
					p_d     = p_q + PW'(1);
					state_d = S_SRC_PG;
				end
			end
			S_FINISH: begin
				if (!rsp_valid_q || !rsp_stall) begin
					load_rsp = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= TW'(MAX_PAGES))
		else $error("page count beyond capacity");

	a_append_one: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INS_NEW) && (total_q != TW'(MAX_PAGES))
		|=> total_q == $past(total_q) + TW'(1))
		else $error("append did not add exactly one page");

	a_search_keeps_total: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SRC_PG || state_q == S_SRC_CNT || state_q == S_SRC_RD
		|| state_q == S_SRC_CMP) |=> $stable(total_q))
		else $error("page count changed during search");

	a_search_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SRC_CMP || state_q == S_SRC_CNT) |-> TW'(p_q) < total_q)
		else $error("search walked past allocated pages");

	a_result_issued: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FINISH) && (!rsp_valid_q || !rsp_stall)
		|=> rsp_valid_q && (state_q == S_IDLE))
		else $error("finished transaction not presented");

endmodule
